// File: hw/rtl/bgc_pkg.sv
// Shared types, register map and pin-mask helpers for the banked GPIO controller.
// No dependencies.
package bgc_pkg;

    localparam int DATA_W      = 32;
    localparam int IRQ_W       = 2;
    localparam int IDX_W       = 4;
    localparam int BANK_STRIDE = 16;

    localparam int NUM_BANKS_DEF  = 2;
    localparam int BANK_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    localparam logic [IDX_W-1:0] REG_BANK_EN    = 4'd0;
    localparam logic [IDX_W-1:0] REG_DIR        = 4'd1;
    localparam logic [IDX_W-1:0] REG_OUT_DATA   = 4'd2;
    localparam logic [IDX_W-1:0] REG_SET_DATA   = 4'd3;
    localparam logic [IDX_W-1:0] REG_CLR_DATA   = 4'd4;
    localparam logic [IDX_W-1:0] REG_IN_DATA    = 4'd5;
    localparam logic [IDX_W-1:0] REG_SET_RISE   = 4'd6;
    localparam logic [IDX_W-1:0] REG_CLR_RISE   = 4'd7;
    localparam logic [IDX_W-1:0] REG_SET_FALL   = 4'd8;
    localparam logic [IDX_W-1:0] REG_CLR_FALL   = 4'd9;
    localparam logic [IDX_W-1:0] REG_INT_STATUS = 4'd10;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [DATA_W-1:0] pin_out;
        logic [DATA_W-1:0] pin_drive_enable;
        logic [IRQ_W-1:0]  bank_irq;
    } result_t;

    function automatic logic [DATA_W-1:0] bank_pins(input int b, input int nb, input int bw);
        logic [DATA_W-1:0] low;
        low = (DATA_W'(1) << bw) - DATA_W'(1);
        if (b >= nb || b >= IRQ_W) begin
            return '0;
        end
        return low << (BANK_STRIDE * b);
    endfunction

    function automatic logic [DATA_W-1:0] pin_mask(input int nb, input int bw);
        return bank_pins(0, nb, bw) | bank_pins(1, nb, bw);
    endfunction

    function automatic logic [IRQ_W-1:0] bank_bits(input int nb);
        return (nb >= 2) ? 2'b11 : 2'b01;
    endfunction

endpackage

// File: hw/rtl/bgc_regs.sv
// Register file, edge detection and interrupt logic of the GPIO controller.
// Depends on bgc_pkg.
module bgc_regs
    import bgc_pkg::*;
#(
    parameter int NUM_BANKS  = NUM_BANKS_DEF,
    parameter int BANK_WIDTH = BANK_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_accept,
    input  logic [1:0]        req_type,
    input  logic [IDX_W-1:0]  reg_index,
    input  logic [DATA_W-1:0] write_data,
    input  logic [DATA_W-1:0] pin_levels,
    output result_t           result
);

    localparam logic [DATA_W-1:0] PinMask  = pin_mask(NUM_BANKS, BANK_WIDTH);
    localparam logic [IRQ_W-1:0]  BankBits = bank_bits(NUM_BANKS);

    logic [IRQ_W-1:0]  bank_en_reg,  bank_en_next;
    logic [DATA_W-1:0] dir_reg,      dir_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [DATA_W-1:0] rise_reg,     rise_next;
    logic [DATA_W-1:0] fall_reg,     fall_next;
    logic [DATA_W-1:0] status_reg,   status_next;
    logic [DATA_W-1:0] last_reg,     last_next;

    logic [DATA_W-1:0] wd;
    logic [DATA_W-1:0] now_pins;
    logic [DATA_W-1:0] rd;
    logic [IRQ_W-1:0]  irq;

    assign wd       = write_data & PinMask;
    assign now_pins = pin_levels & PinMask;

    always_comb begin
        bank_en_next  = bank_en_reg;
        dir_next      = dir_reg;
        out_data_next = out_data_reg;
        rise_next     = rise_reg;
        fall_next     = fall_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        if (req_accept && req_type == REQ_WRITE) begin
            case (reg_index)
                REG_BANK_EN:    bank_en_next  = write_data[IRQ_W-1:0] & BankBits;
                REG_DIR:        dir_next      = wd;
                REG_OUT_DATA:   out_data_next = wd;
                REG_SET_DATA:   out_data_next = out_data_reg | wd;
                REG_CLR_DATA:   out_data_next = out_data_reg & ~wd;
                REG_SET_RISE:   rise_next     = rise_reg | wd;
                REG_CLR_RISE:   rise_next     = rise_reg & ~wd;
                REG_SET_FALL:   fall_next     = fall_reg | wd;
                REG_CLR_FALL:   fall_next     = fall_reg & ~wd;
                REG_INT_STATUS: status_next   = status_reg & ~wd;
                default: ;
            endcase
        end else if (req_accept && req_type == REQ_TICK) begin
            status_next = (status_reg
                           | (now_pins & ~last_reg & rise_reg)
                           | (~now_pins & last_reg & fall_reg)) & PinMask;
            last_next   = now_pins;
        end
    end

    always_comb begin
        rd = '0;
        if (req_type == REQ_READ) begin
            case (reg_index)
                REG_BANK_EN:    rd = {{(DATA_W-IRQ_W){1'b0}}, bank_en_reg};
                REG_DIR:        rd = dir_reg;
                REG_OUT_DATA,
                REG_SET_DATA,
                REG_CLR_DATA:   rd = out_data_reg;
                REG_IN_DATA:    rd = last_reg;
                REG_SET_RISE,
                REG_CLR_RISE:   rd = rise_reg;
                REG_SET_FALL,
                REG_CLR_FALL:   rd = fall_reg;
                REG_INT_STATUS: rd = status_reg;
                default:        rd = '0;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < IRQ_W; b++) begin
            irq[b] = bank_en_next[b] && |(status_next & bank_pins(b, NUM_BANKS, BANK_WIDTH));
        end
    end

    assign result.read_data        = rd;
    assign result.pin_out          = out_data_next;
    assign result.pin_drive_enable = ~dir_next & PinMask;
    assign result.bank_irq         = irq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_en_reg  <= '0;
            dir_reg      <= PinMask;
            out_data_reg <= '0;
            rise_reg     <= '0;
            fall_reg     <= '0;
            status_reg   <= '0;
            last_reg     <= '0;
        end else begin
            bank_en_reg  <= bank_en_next;
            dir_reg      <= dir_next;
            out_data_reg <= out_data_next;
            rise_reg     <= rise_next;
            fall_reg     <= fall_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

endmodule

// File: hw/rtl/bgc_out_stage.sv
// Result register with valid/ready handshake; refills in the cycle it drains.
// Depends on bgc_pkg.
module bgc_out_stage
    import bgc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg, valid_next;
    result_t data_reg,  data_next;

    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = result;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule

// File: hw/rtl/banked_gpio_controller.sv
// Top level of the banked GPIO controller: register file plus result register.
// Depends on bgc_pkg, bgc_regs, bgc_out_stage.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+----------------
//  request | s_req_type, s_reg_index, s_write_data, s_pin_levels | s_valid/s_ready
//  result  | m_read_data, m_pin_out, m_pin_drive_enable, m_bank_irq | m_valid/m_ready
//
// One request per cycle while s_ready is high; its result is registered and appears in the cycle after acceptance.
// Register state updates at the accepting edge; the result shows state after it.
// s_ready is low only while a result is held and m_ready is low.
// aresetn (synchronous): all pins inputs, enables, triggers and status cleared.
module banked_gpio_controller
    import bgc_pkg::*;
#(
    parameter int NUM_BANKS  = NUM_BANKS_DEF,
    parameter int BANK_WIDTH = BANK_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [IDX_W-1:0]  s_reg_index,
    input  logic [DATA_W-1:0] s_write_data,
    input  logic [DATA_W-1:0] s_pin_levels,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [DATA_W-1:0] m_pin_out,
    output logic [DATA_W-1:0] m_pin_drive_enable,
    output logic [IRQ_W-1:0]  m_bank_irq
);

    logic    accept;
    logic    can_load;
    result_t result;
    result_t m_result;

    assign s_ready = can_load;
    assign accept  = s_valid && can_load;

    bgc_regs #(
        .NUM_BANKS  (NUM_BANKS),
        .BANK_WIDTH (BANK_WIDTH)
    ) u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_accept (accept),
        .req_type   (s_req_type),
        .reg_index  (s_reg_index),
        .write_data (s_write_data),
        .pin_levels (s_pin_levels),
        .result     (result)
    );

    bgc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_read_data        = m_result.read_data;
    assign m_pin_out          = m_result.pin_out;
    assign m_pin_drive_enable = m_result.pin_drive_enable;
    assign m_bank_irq         = m_result.bank_irq;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for banked_gpio_controller: directed table, then random requests.
// Depends on bgc_pkg, banked_gpio_controller RTL; results checked by predictor or table rows.
module testbench;
    import bgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_BANKS      = NUM_BANKS_DEF;
    localparam int TB_BANK_W     = BANK_WIDTH_DEF;
    localparam int RANDOM_REQS   = 1800;
    localparam int IDLE_LIMIT    = 500;
    localparam int N_DIRECTED    = 26;

    localparam logic [1:0]       REQ_UNUSED     = 2'd3;
    localparam logic [IDX_W-1:0] REG_NONE_FIRST = 4'd11;
    localparam logic [IDX_W-1:0] REG_NONE_LAST  = 4'd15;

    typedef struct packed {
        logic [1:0]        req;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] pins;
        logic              typed;
        result_t           exp;
    } gpio_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_req_type = REQ_READ;
    logic [IDX_W-1:0]  s_reg_index = '0;
    logic [DATA_W-1:0] s_write_data = '0;
    logic [DATA_W-1:0] s_pin_levels = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_read_data;
    logic [DATA_W-1:0] m_pin_out;
    logic [DATA_W-1:0] m_pin_drive_enable;
    logic [IRQ_W-1:0]  m_bank_irq;

    // predicted register state
    logic [IRQ_W-1:0]  gpio_bank_en;
    logic [DATA_W-1:0] gpio_dir;
    logic [DATA_W-1:0] gpio_out;
    logic [DATA_W-1:0] gpio_rise;
    logic [DATA_W-1:0] gpio_fall;
    logic [DATA_W-1:0] gpio_status;
    logic [DATA_W-1:0] gpio_last;

    result_t pending_results [$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    bit      quiet_phase = 1'b0;

    gpio_row_t directed_reqs [N_DIRECTED] = '{
        '{REQ_READ,   REG_DIR,        32'h0,         32'h0,         1'b1,
          '{32'hFFFF_FFFF, 32'h0, 32'h0, 2'b00}},
        '{REQ_READ,   REG_BANK_EN,    32'h0,         32'h0,         1'b1,
          '{32'h0, 32'h0, 32'h0, 2'b00}},
        '{REQ_WRITE,  REG_DIR,        32'h0000_FFFF, 32'h0,         1'b1,
          '{32'h0, 32'h0, 32'hFFFF_0000, 2'b00}},
        '{REQ_WRITE,  REG_OUT_DATA,   32'hFFFF_FFFF, 32'h0,         1'b1,
          '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_0000, 2'b00}},
        '{REQ_WRITE,  REG_CLR_DATA,   32'h0F0F_0F0F, 32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_SET_DATA,   32'h0000_0001, 32'h0,         1'b0, '0},
        '{REQ_READ,   REG_CLR_DATA,   32'h0,         32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_IN_DATA,    32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_READ,   REG_IN_DATA,    32'h0,         32'hFFFF_FFFF, 1'b0, '0},
        '{REQ_WRITE,  REG_NONE_FIRST, 32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_READ,   REG_NONE_LAST,  32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_UNUSED, REG_DIR,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{REQ_WRITE,  REG_SET_RISE,   32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_SET_FALL,   32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_BANK_EN,    32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_TICK,   REG_BANK_EN,    32'h0,         32'hFFFF_FFFF, 1'b0, '0},
        '{REQ_READ,   REG_INT_STATUS, 32'h0,         32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_INT_STATUS, 32'h0000_FFFF, 32'h0,         1'b0, '0},
        '{REQ_TICK,   REG_BANK_EN,    32'h0,         32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_CLR_RISE,   32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_CLR_FALL,   32'h0000_FFFF, 32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_INT_STATUS, 32'hFFFF_FFFF, 32'h0,         1'b0, '0},
        '{REQ_TICK,   REG_BANK_EN,    32'h0,         32'h8000_0001, 1'b0, '0},
        '{REQ_TICK,   REG_BANK_EN,    32'h0,         32'h0,         1'b0, '0},
        '{REQ_READ,   REG_SET_FALL,   32'h0,         32'h0,         1'b0, '0},
        '{REQ_WRITE,  REG_DIR,        32'h0,         32'h0,         1'b0, '0}
    };

    banked_gpio_controller dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_reg_index        (s_reg_index),
        .s_write_data       (s_write_data),
        .s_pin_levels       (s_pin_levels),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_read_data        (m_read_data),
        .m_pin_out          (m_pin_out),
        .m_pin_drive_enable (m_pin_drive_enable),
        .m_bank_irq         (m_bank_irq)
    );

    always #5 aclk = ~aclk;

    function automatic logic [DATA_W-1:0] bank_span(input int b);
        logic [DATA_W-1:0] low;
        low = '0;
        if (b >= TB_BANKS) begin
            return '0;
        end
        for (int i = 0; i < TB_BANK_W; i++) begin
            low[i] = 1'b1;
        end
        return low << (BANK_STRIDE * b);
    endfunction

    function automatic logic [DATA_W-1:0] impl_pins();
        return bank_span(0) | bank_span(1);
    endfunction

    function automatic void gpio_reset();
        gpio_bank_en = '0;
        gpio_dir     = impl_pins();
        gpio_out     = '0;
        gpio_rise    = '0;
        gpio_fall    = '0;
        gpio_status  = '0;
        gpio_last    = '0;
    endfunction

    function automatic result_t gpio_predict(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                                             input logic [DATA_W-1:0] wd,
                                             input logic [DATA_W-1:0] pins);
        result_t           r;
        logic [DATA_W-1:0] pm;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] now;
        r  = '0;
        pm = impl_pins();
        d  = wd & pm;
        case (req)
            REQ_READ: begin
                case (idx)
                    REG_BANK_EN:                              r.read_data = DATA_W'(gpio_bank_en);
                    REG_DIR:                                  r.read_data = gpio_dir;
                    REG_OUT_DATA, REG_SET_DATA, REG_CLR_DATA: r.read_data = gpio_out;
                    REG_IN_DATA:                              r.read_data = gpio_last;
                    REG_SET_RISE, REG_CLR_RISE:               r.read_data = gpio_rise;
                    REG_SET_FALL, REG_CLR_FALL:               r.read_data = gpio_fall;
                    REG_INT_STATUS:                           r.read_data = gpio_status;
                    default:                                  r.read_data = '0;
                endcase
            end
            REQ_WRITE: begin
                case (idx)
                    REG_BANK_EN:    gpio_bank_en = wd[IRQ_W-1:0] & ((TB_BANKS >= 2) ? 2'b11 : 2'b01);
                    REG_DIR:        gpio_dir = d;
                    REG_OUT_DATA:   gpio_out = d;
                    REG_SET_DATA:   gpio_out = gpio_out | d;
                    REG_CLR_DATA:   gpio_out = gpio_out & ~d;
                    REG_SET_RISE:   gpio_rise = gpio_rise | d;
                    REG_CLR_RISE:   gpio_rise = gpio_rise & ~d;
                    REG_SET_FALL:   gpio_fall = gpio_fall | d;
                    REG_CLR_FALL:   gpio_fall = gpio_fall & ~d;
                    REG_INT_STATUS: gpio_status = gpio_status & ~d;
                    default: ;
                endcase
            end
            REQ_TICK: begin
                now = pins & pm;
                gpio_status = (gpio_status | (now & ~gpio_last & gpio_rise)
                               | (~now & gpio_last & gpio_fall)) & pm;
                gpio_last = now;
            end
            default: ;
        endcase
        r.pin_out          = gpio_out;
        r.pin_drive_enable = ~gpio_dir & pm;
        for (int b = 0; b < IRQ_W; b++) begin
            r.bank_irq[b] = gpio_bank_en[b] && ((gpio_status & bank_span(b)) != '0);
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            3:       return 32'h0000_FFFF;
            4:       return 32'hFFFF_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic [1:0] req, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] pins,
                            input bit drain_first, input bit typed, input result_t exp);
        int      gap;
        result_t predicted;
        gap = quiet_phase ? 0 : $urandom_range(0, 5);
        if (drain_first || gap > 0) begin
            s_valid <= 1'b0;
        end
        if (drain_first) begin
            do @(posedge aclk); while (pending_results.size() != 0);
        end
        repeat (gap) @(posedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_reg_index  <= idx;
        s_write_data <= wd;
        s_pin_levels <= pins;
        do @(posedge aclk); while (!s_ready);
        predicted = gpio_predict(req, idx, wd, pins);
        pending_results.push_back(typed ? exp : predicted);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp,
                               input logic [DATA_W-1:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %h got %h", $time, name, exp, act);
            mismatch_count++;
        end
    endtask

    // result monitor
    always @(posedge aclk) begin
        result_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none got %h %h %h %h", $time,
                         m_read_data, m_pin_out, m_pin_drive_enable, m_bank_irq);
                mismatch_count++;
            end else begin
                exp = pending_results.pop_front();
                check_field("read_data", exp.read_data, m_read_data);
                check_field("pin_out", exp.pin_out, m_pin_out);
                check_field("pin_drive_enable", exp.pin_drive_enable, m_pin_drive_enable);
                check_field("bank_irq", DATA_W'(exp.bank_irq), DATA_W'(m_bank_irq));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("banked_gpio_controller: mismatch");
            $finish;
        end
    end

    // result-side back-pressure
    initial begin
        int stall;
        repeat (11) @(posedge aclk);
        forever begin
            stall = quiet_phase ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [1:0]        req;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] pins;
        int                pick;
        gpio_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_reqs[i]) begin
            send_req(directed_reqs[i].req, directed_reqs[i].idx, directed_reqs[i].wd,
                     directed_reqs[i].pins, 1'b0, directed_reqs[i].typed, directed_reqs[i].exp);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            quiet_phase = ((n / 150) % 4) == 3;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                req = REQ_UNUSED;
            end else if (pick < 30) begin
                req = REQ_READ;
            end else if (pick < 70) begin
                req = REQ_WRITE;
            end else begin
                req = REQ_TICK;
            end
            idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(11, 15))
                                              : IDX_W'($urandom_range(0, 10));
            wd  = pick_word();
            case ($urandom_range(0, 3))
                0:       pins = $urandom;
                1:       pins = gpio_last ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1))
                                ^ (DATA_W'(1) << $urandom_range(0, DATA_W - 1));
                2:       pins = ~gpio_last;
                default: pins = gpio_last ^ pick_word();
            endcase
            send_req(req, idx, wd, pins, (n == 600) || (n == 1300), 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("banked_gpio_controller: match");
        end else begin
            $display("banked_gpio_controller: mismatch");
        end
        $finish;
    end

endmodule
